@@ rtl/dhlcd_pkg.sv @@
// Package: item types, command codes and limits for the dual-half LCD bus emulator.
`timescale 1ns / 1ps

package dhlcd_pkg;

    // Row limit; the row state is 6 bits wide, so the effective limit clips at 63
    localparam int ROW_LIMIT = 63;
    localparam int ROW_MAX   = (ROW_LIMIT > 63) ? 63 : ROW_LIMIT;

    localparam int LEFT_COL_MAX  = 19;
    localparam int RIGHT_COL_MAX = 11;
    localparam int RIGHT_OFFSET  = 40;

    // Queue between the front and back parts
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Controller command codes
    localparam logic [7:0] CMD_PIXEL  = 8'h20;
    localparam logic [7:0] CMD_COLUMN = 8'h21;
    localparam logic [7:0] CMD_ROW    = 8'h22;
    localparam logic [7:0] CMD_MODE   = 8'h23;

    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_STATUS = 2'd1,
        ACT_REPOS  = 2'd2,
        ACT_PIXEL  = 2'd3
    } action_t;

    // One bus sample
    typedef struct packed {
        logic       wr_level;
        logic       rd_level;
        logic       sel_left_n;
        logic       sel_right_n;
        logic       is_data;
        logic [7:0] bus_byte;
    } in_item_t;

    // One result
    typedef struct packed {
        action_t    action;
        logic [5:0] column;
        logic [5:0] row;
        logic       horizontal_inc;
        logic [7:0] pixel_byte;
        logic [7:0] status_out;
        logic       drive_bus;
    } out_item_t;

    // Classified sample handed from the front part to the back part
    typedef struct packed {
        logic       wr_event;   // write strobe rose with a half selected
        logic       right_half; // 1: right half, 0: left half
        logic       is_data;
        logic [7:0] data_byte;
        logic       drive;      // bus drive state after this sample
    } op_t;

endpackage

@@ rtl/dual_half_lcd_bus_emulator_core.sv @@
// An accepted item passes through the queue and then the result register on its way out,
// given an idle result port.
// Throughput: one item per cycle; a 4-entry queue between front and back absorbs
// result stalls, and s_ready drops only when that queue is full.
// Reset (aresetn low, synchronous): both halves, command and status bytes clear,
// strobe history goes to idle high, the bus is released and the queue empties.
`timescale 1ns / 1ps

module dual_half_lcd_bus_emulator_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  dhlcd_pkg::in_item_t  s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output dhlcd_pkg::out_item_t m_item
);
    import dhlcd_pkg::*;

    logic queue_full;
    logic queue_not_empty;
    logic push;
    logic pop;
    op_t  push_op;
    op_t  head_op;

    dhlcd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .queue_full (queue_full),
        .push       (push),
        .push_op    (push_op)
    );

    dhlcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_op   (head_op)
    );

    dhlcd_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (queue_not_empty),
        .op       (head_op),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item)
    );

    // Fields that the action does not use are zero
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.action != ACT_REPOS) |->
            (m_item.column == 6'd0 && m_item.row == 6'd0 && !m_item.horizontal_inc))
        else $error("reposition fields set without a reposition");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.action != ACT_PIXEL) |-> (m_item.pixel_byte == 8'd0))
        else $error("pixel byte set without a pixel action");

    // Columns are always even: both the doubling and the right-half offset keep bit 0 clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_item.action == ACT_REPOS) |-> (m_item.column[0] == 1'b0))
        else $error("odd display column on reposition");

    // A popped item always lands in the result register
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_valid)
        else $error("popped item did not reach the result register");

endmodule

@@ rtl/dhlcd_front.sv @@
// Front part: strobe edge detection, chip select decode and bus drive tracking.
`timescale 1ns / 1ps

module dhlcd_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  dhlcd_pkg::in_item_t s_item,
    input  logic               queue_full,
    output logic               push,
    output dhlcd_pkg::op_t     push_op
);
    import dhlcd_pkg::*;

    logic prev_wr_reg, prev_wr_next;
    logic prev_rd_reg, prev_rd_next;
    logic driving_reg, driving_next;

    assign s_ready = !queue_full;
    assign push    = s_valid && s_ready;

    // Read strobe: falling edge drives the bus, rising edge releases it
    always_comb begin
        driving_next = driving_reg;
        if (!s_item.rd_level && prev_rd_reg) begin
            driving_next = 1'b1;
        end else if (s_item.rd_level && !prev_rd_reg) begin
            driving_next = 1'b0;
        end
        prev_wr_next = s_item.wr_level;
        prev_rd_next = s_item.rd_level;
    end

    // Classify the sample; the left select has priority
    always_comb begin
        push_op.wr_event   = s_item.wr_level && !prev_wr_reg &&
                             (!s_item.sel_left_n || !s_item.sel_right_n);
        push_op.right_half = s_item.sel_left_n;
        push_op.is_data    = s_item.is_data;
        push_op.data_byte  = s_item.bus_byte;
        push_op.drive      = driving_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_wr_reg <= 1'b1;
            prev_rd_reg <= 1'b1;
            driving_reg <= 1'b0;
        end else if (push) begin
            prev_wr_reg <= prev_wr_next;
            prev_rd_reg <= prev_rd_next;
            driving_reg <= driving_next;
        end
    end

endmodule

@@ rtl/dhlcd_queue.sv @@
// Short FIFO of classified items between the front and back parts.
`timescale 1ns / 1ps

module dhlcd_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  dhlcd_pkg::op_t push_op,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output dhlcd_pkg::op_t head_op
);
    import dhlcd_pkg::*;

    op_t                entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]  count_reg, count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_op   = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ rtl/dhlcd_back.sv @@
// Back part: per-half display state, command execution and the result register.
`timescale 1ns / 1ps

module dhlcd_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                op_valid,
    input  dhlcd_pkg::op_t      op,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output dhlcd_pkg::out_item_t m_item
);
    import dhlcd_pkg::*;

    logic [4:0] left_col_reg, left_col_next;
    logic [5:0] left_row_reg, left_row_next;
    logic [7:0] left_cmd_reg, left_cmd_next;
    logic       left_hor_reg, left_hor_next;
    logic [3:0] right_col_reg, right_col_next;
    logic [5:0] right_row_reg, right_row_next;
    logic [7:0] right_cmd_reg, right_cmd_next;
    logic       right_hor_reg, right_hor_next;
    logic [7:0] status_reg, status_next;

    logic       m_valid_reg;
    out_item_t  m_item_reg, m_item_next;

    // Selected half, before and after this item
    logic [4:0] cur_col, new_col, col_max;
    logic [5:0] cur_row, new_row;
    logic [7:0] cur_cmd, new_cmd;
    logic       cur_hor, new_hor;
    action_t    act;

    assign pop     = op_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    // Execute the item against the selected half
    always_comb begin
        cur_col = op.right_half ? {1'b0, right_col_reg} : left_col_reg;
        cur_row = op.right_half ? right_row_reg : left_row_reg;
        cur_cmd = op.right_half ? right_cmd_reg : left_cmd_reg;
        cur_hor = op.right_half ? right_hor_reg : left_hor_reg;
        col_max = op.right_half ? 5'(RIGHT_COL_MAX) : 5'(LEFT_COL_MAX);
        new_col     = cur_col;
        new_row     = cur_row;
        new_cmd     = cur_cmd;
        new_hor     = cur_hor;
        status_next = status_reg;
        act         = ACT_NONE;
        if (op.wr_event) begin
            if (!op.is_data) begin
                new_cmd     = op.data_byte;
                status_next = (op.data_byte == CMD_PIXEL) ? 8'h00 : op.data_byte;
                act         = ACT_STATUS;
            end else begin
                unique case (cur_cmd)
                    CMD_MODE: begin
                        new_hor = op.data_byte[7];
                    end
                    CMD_ROW: begin
                        if (op.data_byte <= 8'(ROW_MAX)) begin
                            new_row = op.data_byte[5:0];
                        end
                        act = ACT_REPOS;
                    end
                    CMD_COLUMN: begin
                        if (op.data_byte <= {3'b000, col_max}) begin
                            new_col = op.data_byte[4:0];
                        end
                        act = ACT_REPOS;
                    end
                    CMD_PIXEL: begin
                        act = ACT_PIXEL;
                        if (cur_hor) begin
                            if (cur_col < col_max) begin
                                new_col = cur_col + 1'b1;
                            end
                        end else if (cur_row < 6'(ROW_MAX)) begin
                            new_row = cur_row + 1'b1;
                        end
                    end
                    default: begin
                        act = ACT_NONE;
                    end
                endcase
            end
        end
    end

    // Next state of both halves
    always_comb begin
        left_col_next  = left_col_reg;
        left_row_next  = left_row_reg;
        left_cmd_next  = left_cmd_reg;
        left_hor_next  = left_hor_reg;
        right_col_next = right_col_reg;
        right_row_next = right_row_reg;
        right_cmd_next = right_cmd_reg;
        right_hor_next = right_hor_reg;
        if (op.right_half) begin
            right_col_next = new_col[3:0];
            right_row_next = new_row;
            right_cmd_next = new_cmd;
            right_hor_next = new_hor;
        end else begin
            left_col_next = new_col;
            left_row_next = new_row;
            left_cmd_next = new_cmd;
            left_hor_next = new_hor;
        end
    end

    // Result fields; unused fields read as zero
    always_comb begin
        m_item_next                = '0;
        m_item_next.action         = act;
        m_item_next.status_out     = status_next;
        m_item_next.drive_bus      = op.drive;
        if (act == ACT_REPOS) begin
            m_item_next.column = {new_col, 1'b0} +
                                 (op.right_half ? 6'(RIGHT_OFFSET) : 6'd0);
            m_item_next.row            = new_row;
            m_item_next.horizontal_inc = new_hor;
        end
        if (act == ACT_PIXEL) begin
            m_item_next.pixel_byte = op.data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_col_reg  <= '0;
            left_row_reg  <= '0;
            left_cmd_reg  <= '0;
            left_hor_reg  <= 1'b0;
            right_col_reg <= '0;
            right_row_reg <= '0;
            right_cmd_reg <= '0;
            right_hor_reg <= 1'b0;
            status_reg    <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (pop) begin
                left_col_reg  <= left_col_next;
                left_row_reg  <= left_row_next;
                left_cmd_reg  <= left_cmd_next;
                left_hor_reg  <= left_hor_next;
                right_col_reg <= right_col_next;
                right_row_reg <= right_row_next;
                right_cmd_reg <= right_cmd_next;
                right_hor_reg <= right_hor_next;
                status_reg    <= status_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (pop) begin
            m_item_reg <= m_item_next;
        end
    end

endmodule
